[hw/rtl/bes_pkg.sv]
// Shared types, constants and the exponent root table of the Bose-Einstein scaler.
package bes_pkg;

   // Field widths.
   localparam int WN_W     = 24;
   localparam int INT_W    = 32;
   localparam int TEMP_W   = 20;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   // Temperature after reset: 293 K in units of 1/16 K.
   localparam logic [TEMP_W-1:0] TEMP_RESET = 20'd4688;

   // Register addresses.
   localparam logic [CSR_AW-1:0] CSR_TEMPERATURE = 2'd0;

   // hc/k = 1.4387 in Q24 and log2(e) in Q30.
   localparam logic [24:0] HC_Q24  = 25'd24137381;
   localparam logic [30:0] L2E_Q30 = 31'd1549082005;

   // Divider geometry: quotient bits kept, numerator, denominator and remainder widths.
   localparam int QUO_W = 21;
   localparam int NUM_W = 48;
   localparam int DEN_W = 32;
   localparam int REM_W = 53;

   // Clamp of |x| at 16.0 in Q16.
   localparam logic [QUO_W-1:0] X_CLAMP = 21'h100000;

   // Default number of fractional bits of the scale factor.
   localparam int FACTOR_FRAC_BITS_DEF = 16;

   // Data that travels alongside each point.
   typedef struct packed {
      logic [WN_W-1:0]  wavenumber;
      logic [INT_W-1:0] intensity;
      logic             zero;
   } bes_side_type;

   // Rounded integer square root of n.
   function automatic logic [63:0] bes_isqrt(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bt;
      n   = n_in;
      res = 64'd0;
      bt  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= res + bt) begin
            n   = n - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      if (n > res) begin
         res = res + 64'd1;
      end
      return res;
   endfunction

   // Table entry b: 2^-(2^(b-16)) in Q31, built by repeated square roots.
   function automatic logic [31:0] bes_rom_entry(input int b);
      logic [63:0] v;
      v = 64'd1 << 30;
      for (int j = 15; j >= b; j--) begin
         v = bes_isqrt(v << 31);
      end
      return v[31:0];
   endfunction

endpackage

[hw/rtl/bose_einstein_intensity_scaler_unit.sv]
// Bose-Einstein thermal population correction of spectral points.
// One point (wavenumber, intensity) enters on every cycle at which start is high and
// busy is low; busy is high only while reset is asserted. Each point gives one result,
// shown for exactly one cycle with rsp_valid, after a multiply stage and a rounding stage,
// a 21-stage restoring divider that forms x = 1.4387*w/T, a
// clamp stage, 20 stages of base-two exponent (one table multiply per fraction bit) and
// three stages of scaling and saturation. Results leave in input order and the receiver
// cannot hold them off. The temperature register should be written only while no point
// is in flight.
module bose_einstein_intensity_scaler_unit #(
   parameter int FACTOR_FRAC_BITS = bes_pkg::FACTOR_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [bes_pkg::WN_W-1:0]   req_wavenumber,
   input  logic [bes_pkg::INT_W-1:0]  req_intensity_in,
   output logic                       rsp_valid,
   output logic [bes_pkg::WN_W-1:0]   rsp_wavenumber_out,
   output logic [bes_pkg::INT_W-1:0]  rsp_intensity_out,
   output logic                       rsp_overflow,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bes_pkg::CSR_AW-1:0] paddr,
   input  logic [bes_pkg::CSR_DW-1:0] pwdata,
   output logic [bes_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import bes_pkg::*;

   localparam int MF_W = FACTOR_FRAC_BITS + 25;

   logic [TEMP_W-1:0] temperature_ff;
   logic [TEMP_W-1:0] temperature_in;
   logic              csr_write;

   logic              in_valid;
   bes_side_type      in_side;

   logic              div_valid;
   bes_side_type      div_side;
   logic [QUO_W-1:0]  div_ax;

   logic              exp_valid;
   bes_side_type      exp_side;
   logic [MF_W-1:0]   exp_mf;
   logic              exp_fneg;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_TEMPERATURE);

   always_comb begin
      temperature_in = temperature_ff;
      if (csr_write) begin
         temperature_in = pwdata[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temperature_ff <= TEMP_RESET;
      end else begin
         temperature_ff <= temperature_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_TEMPERATURE) begin
         prdata = CSR_DW'(temperature_ff);
      end
   end

   // Input transfer.
   assign busy     = reset;
   assign in_valid = start && !busy;

   always_comb begin
      in_side.wavenumber = req_wavenumber;
      in_side.intensity  = req_intensity_in;
      in_side.zero       = (req_wavenumber == '0);
   end

   bes_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid),
      .in_side     (in_side),
      .temperature (temperature_ff),
      .out_valid   (div_valid),
      .out_side    (div_side),
      .out_ax      (div_ax)
   );

   bes_exp #(
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
      .MF_W             (MF_W)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_side   (div_side),
      .in_ax     (div_ax),
      .out_valid (exp_valid),
      .out_side  (exp_side),
      .out_mf    (exp_mf),
      .out_fneg  (exp_fneg)
   );

   bes_scale #(
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
      .MF_W             (MF_W)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (exp_valid),
      .in_side        (exp_side),
      .in_mf          (exp_mf),
      .in_fneg        (exp_fneg),
      .out_valid      (rsp_valid),
      .out_wavenumber (rsp_wavenumber_out),
      .out_intensity  (rsp_intensity_out),
      .out_overflow   (rsp_overflow)
   );

   // An overflow result always carries one of the two limits.
   a_ovf_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         ((rsp_intensity_out == 32'h7FFF_FFFF) || (rsp_intensity_out == 32'h8000_0000)))
      else $error("overflow without a saturated intensity");

   // A zero wavenumber gives a zero intensity and no overflow.
   a_zero_wn : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_wavenumber_out == '0)) |->
         ((rsp_intensity_out == '0) && !rsp_overflow))
      else $error("zero wavenumber gave a non-zero intensity");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // A register write lands in the temperature register.
   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (temperature_ff == $past(pwdata[TEMP_W-1:0])))
      else $error("temperature write lost");

endmodule

[hw/rtl/bes_div.sv]
// Exponent argument x = 1.4387*|w|/T through a pipelined restoring divider.
module bes_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  bes_pkg::bes_side_type         in_side,
   input  logic [bes_pkg::TEMP_W-1:0]    temperature,
   output logic                          out_valid,
   output bes_pkg::bes_side_type         out_side,
   output logic [bes_pkg::QUO_W-1:0]     out_ax
);
   import bes_pkg::*;

   typedef struct packed {
      logic               valid;
      bes_side_type       side;
      logic [REM_W-1:0]   rem;
      logic [QUO_W-1:0]   quo;
      logic               big;
   } bes_div_stage_type;

   logic [DEN_W-1:0] den;
   logic [WN_W-1:0]  aw;

   logic             mul_valid_ff;
   bes_side_type     mul_side_ff;
   logic [NUM_W-1:0] mul_prod_ff;
   logic [NUM_W-1:0] mul_prod_in;

   bes_div_stage_type stage_q [0:QUO_W];
   bes_div_stage_type head_ff;
   bes_div_stage_type head_in;

   logic             out_valid_ff;
   bes_side_type     out_side_ff;
   logic [QUO_W-1:0] out_ax_ff;
   logic [QUO_W-1:0] out_ax_in;

   assign den = {temperature, 12'd0};

   // Magnitude of the wavenumber times hc/k.
   always_comb begin
      aw          = in_side.wavenumber[WN_W-1] ? (WN_W'(0) - in_side.wavenumber)
                                               : in_side.wavenumber;
      mul_prod_in = NUM_W'(HC_Q24 * aw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
      end
      mul_side_ff <= in_side;
      mul_prod_ff <= mul_prod_in;
   end

   // Add half the divisor for rounding and catch quotients beyond the clamp.
   always_comb begin
      head_in       = '0;
      head_in.valid = mul_valid_ff;
      head_in.side  = mul_side_ff;
      head_in.rem   = {5'd0, mul_prod_ff} + {22'd0, temperature, 11'd0};
      head_in.quo   = '0;
      head_in.big   = (head_in.rem >= {den, 21'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else begin
         head_ff.valid <= head_in.valid;
      end
      head_ff.side <= head_in.side;
      head_ff.rem  <= head_in.rem;
      head_ff.quo  <= head_in.quo;
      head_ff.big  <= head_in.big;
   end

   assign stage_q[0] = head_ff;

   // One quotient bit per stage, most significant first.
   for (genvar s = 0; s < QUO_W; s++) begin : g_div
      localparam int BIT = QUO_W - 1 - s;
      logic [REM_W-1:0]  dsh;
      bes_div_stage_type st_in;
      bes_div_stage_type st_ff;

      always_comb begin
         dsh   = {21'd0, den} << BIT;
         st_in = stage_q[s];
         if (stage_q[s].rem >= dsh) begin
            st_in.rem      = stage_q[s].rem - dsh;
            st_in.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff.valid <= 1'b0;
         end else begin
            st_ff.valid <= st_in.valid;
         end
         st_ff.side <= st_in.side;
         st_ff.rem  <= st_in.rem;
         st_ff.quo  <= st_in.quo;
         st_ff.big  <= st_in.big;
      end

      assign stage_q[s+1] = st_ff;
   end

   // Clamp |x| at 16.0.
   always_comb begin
      if (stage_q[QUO_W].big || (stage_q[QUO_W].quo > X_CLAMP)) begin
         out_ax_in = X_CLAMP;
      end else begin
         out_ax_in = stage_q[QUO_W].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= stage_q[QUO_W].valid;
      end
      out_side_ff <= stage_q[QUO_W].side;
      out_ax_ff   <= out_ax_in;
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_ax    = out_ax_ff;

endmodule

[hw/rtl/bes_exp.sv]
// Factor 1 - e^-x from x through a base-two exponent pipeline of table multiplies.
module bes_exp #(
   parameter int FACTOR_FRAC_BITS = bes_pkg::FACTOR_FRAC_BITS_DEF,
   parameter int MF_W             = FACTOR_FRAC_BITS + 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  bes_pkg::bes_side_type     in_side,
   input  logic [bes_pkg::QUO_W-1:0] in_ax,
   output logic                      out_valid,
   output bes_pkg::bes_side_type     out_side,
   output logic [MF_W-1:0]           out_mf,
   output logic                      out_fneg
);
   import bes_pkg::*;

   typedef struct packed {
      logic         valid;
      bes_side_type side;
      logic [15:0]  h;
      logic [7:0]   m;
      logic [31:0]  d;
   } bes_exp_stage_type;

   localparam logic [MF_W-1:0] ONE_F = MF_W'(1) << FACTOR_FRAC_BITS;

   logic         a_valid_ff;
   bes_side_type a_side_ff;
   logic [21:0]  a_zm_ff;
   logic [51:0]  a_prod;
   logic [21:0]  a_zm_in;

   bes_exp_stage_type b_ff;
   bes_exp_stage_type b_in;
   logic [22:0]       zn;

   bes_exp_stage_type chain_q [0:16];

   logic              d_valid_ff;
   bes_side_type      d_side_ff;
   logic [MF_W-1:0]   d_e_ff;
   logic [MF_W-1:0]   d_e_in;
   logic signed [7:0] sh;
   logic [7:0]        k;
   logic [63:0]       dx;
   logic [63:0]       shifted;

   logic              o_valid_ff;
   bes_side_type      o_side_ff;
   logic [MF_W-1:0]   o_mf_ff;
   logic [MF_W-1:0]   o_mf_in;
   logic              o_fneg_ff;
   logic              o_fneg_in;

   // x times log2(e), rounded to Q16.
   always_comb begin
      a_prod  = in_ax * L2E_Q30;
      a_prod  = a_prod + (52'd1 << 29);
      a_zm_in = a_prod[51:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_side_ff <= in_side;
      a_zm_ff   <= a_zm_in;
   end

   // Split the signed exponent into a fractional part and a whole power of two.
   always_comb begin
      zn         = a_side_ff.wavenumber[WN_W-1] ? (23'd0 - {1'b0, a_zm_ff})
                                                : {1'b0, a_zm_ff};
      b_in       = '0;
      b_in.valid = a_valid_ff;
      b_in.side  = a_side_ff;
      b_in.h     = zn[15:0];
      b_in.m     = 8'd0 - {zn[22], zn[22:16]};
      b_in.d     = 32'h8000_0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else begin
         b_ff.valid <= b_in.valid;
      end
      b_ff.side <= b_in.side;
      b_ff.h    <= b_in.h;
      b_ff.m    <= b_in.m;
      b_ff.d    <= b_in.d;
   end

   assign chain_q[0] = b_ff;

   // One table multiply per stage for each set bit of the fraction.
   for (genvar b = 0; b < 16; b++) begin : g_rom
      localparam logic [31:0] ROM_R = bes_rom_entry(b);
      logic [63:0]       prod;
      bes_exp_stage_type st_in;
      bes_exp_stage_type st_ff;

      always_comb begin
         prod  = chain_q[b].d * ROM_R;
         prod  = prod + (64'd1 << 30);
         st_in = chain_q[b];
         if (chain_q[b].h[b]) begin
            st_in.d = prod[62:31];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff.valid <= 1'b0;
         end else begin
            st_ff.valid <= st_in.valid;
         end
         st_ff.side <= st_in.side;
         st_ff.h    <= st_in.h;
         st_ff.m    <= st_in.m;
         st_ff.d    <= st_in.d;
      end

      assign chain_q[b+1] = st_ff;
   end

   // Bring e^-x to the factor's fractional bits, rounding half up.
   always_comb begin
      sh      = $signed(chain_q[16].m) + $signed(8'(FACTOR_FRAC_BITS)) - 8'sd31;
      k       = 8'd0 - sh;
      dx      = {32'd0, chain_q[16].d};
      if (!sh[7]) begin
         shifted = dx << sh[5:0];
      end else begin
         shifted = (dx >> k[5:0]) + {63'd0, dx[k[5:0] - 6'd1]};
      end
      d_e_in = shifted[MF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= chain_q[16].valid;
      end
      d_side_ff <= chain_q[16].side;
      d_e_ff    <= d_e_in;
   end

   // Factor magnitude and sign; a zero wavenumber gives a zero factor.
   always_comb begin
      if (d_side_ff.zero) begin
         o_mf_in   = '0;
         o_fneg_in = 1'b0;
      end else if (d_e_ff > ONE_F) begin
         o_mf_in   = d_e_ff - ONE_F;
         o_fneg_in = 1'b1;
      end else begin
         o_mf_in   = ONE_F - d_e_ff;
         o_fneg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= d_valid_ff;
      end
      o_side_ff <= d_side_ff;
      o_mf_ff   <= o_mf_in;
      o_fneg_ff <= o_fneg_in;
   end

   assign out_valid = o_valid_ff;
   assign out_side  = o_side_ff;
   assign out_mf    = o_mf_ff;
   assign out_fneg  = o_fneg_ff;

endmodule

[hw/rtl/bes_scale.sv]
// Intensity times factor with rounding and saturation to the Q24.8 range.
module bes_scale #(
   parameter int FACTOR_FRAC_BITS = bes_pkg::FACTOR_FRAC_BITS_DEF,
   parameter int MF_W             = FACTOR_FRAC_BITS + 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  bes_pkg::bes_side_type     in_side,
   input  logic [MF_W-1:0]           in_mf,
   input  logic                      in_fneg,
   output logic                      out_valid,
   output logic [bes_pkg::WN_W-1:0]  out_wavenumber,
   output logic [bes_pkg::INT_W-1:0] out_intensity,
   output logic                      out_overflow
);
   import bes_pkg::*;

   localparam int FH_W = MF_W - FACTOR_FRAC_BITS;
   localparam int LO_W = INT_W + FACTOR_FRAC_BITS;
   localparam int HI_W = INT_W + FH_W;
   localparam int Q_W  = HI_W + 1;

   logic [INT_W-1:0] mi;

   logic                        p_valid_ff;
   logic [WN_W-1:0]             p_wn_ff;
   logic [INT_W-1:0]            p_mi_ff;
   logic [FH_W-1:0]             p_fh_ff;
   logic [LO_W-1:0]             p_lo_ff;
   logic [LO_W-1:0]             p_lo_in;
   logic                        p_neg_ff;

   logic                        q_valid_ff;
   logic [WN_W-1:0]             q_wn_ff;
   logic [Q_W-1:0]              q_ff;
   logic [Q_W-1:0]              q_in;
   logic [LO_W:0]               lo_round;
   logic                        q_neg_ff;

   logic                        r_valid_ff;
   logic [WN_W-1:0]             r_wn_ff;
   logic [INT_W-1:0]            r_int_ff;
   logic [INT_W-1:0]            r_int_in;
   logic                        r_ovf_ff;
   logic                        r_ovf_in;

   // Low partial product of |intensity| and the factor's fraction.
   always_comb begin
      mi      = in_side.intensity[INT_W-1] ? (INT_W'(0) - in_side.intensity)
                                           : in_side.intensity;
      p_lo_in = mi * in_mf[FACTOR_FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
      end
      p_wn_ff  <= in_side.wavenumber;
      p_mi_ff  <= mi;
      p_fh_ff  <= in_mf[MF_W-1:FACTOR_FRAC_BITS];
      p_lo_ff  <= p_lo_in;
      p_neg_ff <= in_side.intensity[INT_W-1] ^ in_fneg;
   end

   // High partial product plus the rounded low part.
   always_comb begin
      lo_round = {1'b0, p_lo_ff} + ((LO_W+1)'(1) << (FACTOR_FRAC_BITS - 1));
      q_in     = Q_W'(p_mi_ff * p_fh_ff) + Q_W'(lo_round >> FACTOR_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= p_valid_ff;
      end
      q_wn_ff  <= p_wn_ff;
      q_ff     <= q_in;
      q_neg_ff <= p_neg_ff;
   end

   // Saturate to the signed 32-bit range.
   always_comb begin
      r_ovf_in = 1'b0;
      if (q_neg_ff) begin
         if (q_ff > Q_W'(33'h1_0000_0000 >> 1)) begin
            r_int_in = 32'h8000_0000;
            r_ovf_in = 1'b1;
         end else begin
            r_int_in = INT_W'(0) - q_ff[INT_W-1:0];
         end
      end else begin
         if (q_ff > Q_W'(32'h7FFF_FFFF)) begin
            r_int_in = 32'h7FFF_FFFF;
            r_ovf_in = 1'b1;
         end else begin
            r_int_in = q_ff[INT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= q_valid_ff;
      end
      r_wn_ff  <= q_wn_ff;
      r_int_ff <= r_int_in;
      r_ovf_ff <= r_ovf_in;
   end

   assign out_valid      = r_valid_ff;
   assign out_wavenumber = r_wn_ff;
   assign out_intensity  = r_int_ff;
   assign out_overflow   = r_ovf_ff;

endmodule

[verif/tb.sv]
// Self-checking testbench of the Bose-Einstein intensity scaler unit.
`timescale 1ns / 100ps

module tb;
   import bes_pkg::*;

   localparam int FRAC      = FACTOR_FRAC_BITS_DEF;
   localparam int LATENCY   = 47;
   localparam int MAX_CYCLE = 400000;

   // One spectral point with its optional hand-typed outcome.
   typedef struct {
      logic [WN_W-1:0]  wn;
      logic [INT_W-1:0] inten;
      bit               typed;
      logic [INT_W-1:0] exp_inten;
      logic             exp_ovf;
   } point_row_type;

   // One expected result.
   typedef struct {
      logic [WN_W-1:0]  wn;
      logic [INT_W-1:0] inten;
      logic             ovf;
   } scaled_point_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [WN_W-1:0]     req_wavenumber = '0;
   logic [INT_W-1:0]    req_intensity_in = '0;
   logic                rsp_valid;
   logic [WN_W-1:0]     rsp_wavenumber_out;
   logic [INT_W-1:0]    rsp_intensity_out;
   logic                rsp_overflow;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   scaled_point_type    pending_points[$];
   logic [31:0]         exp2_roots[16];
   logic [TEMP_W-1:0]   temp_kelvin16 = TEMP_RESET;
   int                  cycle_count = 0;
   bit                  failed = 1'b0;
   bit                  burst = 1'b0;

   bose_einstein_intensity_scaler_unit i_dut (
      .clock, .reset, .start, .busy, .req_wavenumber, .req_intensity_in, .rsp_valid,
      .rsp_wavenumber_out, .rsp_intensity_out, .rsp_overflow, .psel, .penable, .pwrite,
      .paddr, .pwdata, .prdata, .pready
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Square root rounded to nearest.
   function automatic logic [63:0] root_nearest(input logic [63:0] val);
      logic [63:0] rem;
      logic [63:0] acc;
      logic [63:0] probe;
      rem   = val;
      acc   = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= acc + probe) begin
            rem = rem - (acc + probe);
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
         probe = probe >> 2;
      end
      if (rem > acc) acc = acc + 1;
      return acc;
   endfunction

   // Scale factor 1 - e^-x in Q(FRAC) for one wavenumber at the current temperature.
   function automatic longint thermal_factor(input logic [WN_W-1:0] wn);
      longint      wv;
      logic [63:0] aw;
      logic [63:0] ax;
      logic [63:0] den;
      logic [63:0] zm;
      logic [63:0] d;
      logic [63:0] e;
      longint      zn;
      longint      h;
      longint      m;
      longint      s;
      wv = longint'($signed(wn));
      aw = (wv < 0) ? -wv : wv;
      if (aw == 0) return 0;
      if (temp_kelvin16 == 0) begin
         ax = 64'(X_CLAMP);
      end else begin
         den = 64'(temp_kelvin16) << 12;
         ax  = (64'(HC_Q24) * aw + (den >> 1)) / den;
         if (ax > 64'(X_CLAMP)) ax = 64'(X_CLAMP);
      end
      zm = (ax * 64'(L2E_Q30) + (64'd1 << 29)) >> 30;
      zn = (wv < 0) ? -longint'(zm) : longint'(zm);
      h  = zn & 64'hFFFF;
      m  = -((zn - h) >>> 16);
      d  = 64'd1 << 31;
      for (int b = 0; b < 16; b++) begin
         if (h[b]) d = (d * 64'(exp2_roots[b]) + (64'd1 << 30)) >> 31;
      end
      s = m + FRAC - 31;
      if (s >= 0) e = d << s;
      else        e = (d + (64'd1 << (-s - 1))) >> (-s);
      return (longint'(1) << FRAC) - longint'(e);
   endfunction

   // Expected output of one point: scaled, rounded and saturated intensity.
   function automatic scaled_point_type scale_point(input logic [WN_W-1:0] wn,
                                                    input logic [INT_W-1:0] inten);
      scaled_point_type res;
      longint           f;
      longint           iv;
      logic [63:0]      mi;
      logic [63:0]      mf;
      logic [63:0]      q;
      bit               neg;
      f   = thermal_factor(wn);
      iv  = longint'($signed(inten));
      mi  = (iv < 0) ? -iv : iv;
      mf  = (f < 0) ? -f : f;
      q   = mi * (mf >> FRAC)
            + ((mi * (mf & ((64'd1 << FRAC) - 1)) + (64'd1 << (FRAC - 1))) >> FRAC);
      neg = (iv < 0) != (f < 0);
      res.wn  = wn;
      res.ovf = 1'b0;
      if (neg) begin
         if (q > 64'd2147483648) begin
            q = 64'd2147483648;
            res.ovf = 1'b1;
         end
         res.inten = 32'(-q);
      end else begin
         if (q > 64'd2147483647) begin
            q = 64'd2147483647;
            res.ovf = 1'b1;
         end
         res.inten = 32'(q);
      end
      return res;
   endfunction

   // Appends one expectation behind the ones still outstanding.
   function automatic void queue_expected(input scaled_point_type item);
      pending_points.insert(pending_points.size(), item);
   endfunction

   // Sends one point; start stays high when the next one follows at once.
   task automatic send_point(input logic [WN_W-1:0] wn, input logic [INT_W-1:0] inten,
                             input bit typed, input scaled_point_type typed_res);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_wavenumber   <= wn;
      req_intensity_in <= inten;
      do @(posedge clock); while (busy);
      queue_expected(typed ? typed_res : scale_point(wn, inten));
   endtask

   // Waits for the pipeline to drain, then writes the temperature register.
   task automatic write_temperature(input logic [TEMP_W-1:0] value);
      start <= 1'b0;
      wait (pending_points.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= CSR_TEMPERATURE;
      pwdata  <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      temp_kelvin16 = value;
   endtask

   // Random point: mostly moderate shifts so x stays inside the clamp.
   task automatic send_random_point();
      logic [WN_W-1:0]  wn;
      logic [INT_W-1:0] inten;
      scaled_point_type none;
      none = '{default: '0};
      case ($urandom_range(0, 3))
         0:       wn = WN_W'($urandom);
         1:       wn = WN_W'($urandom_range(0, 2047)) - WN_W'(1024);
         default: wn = WN_W'($urandom_range(0, 1 << 20)) - WN_W'(1 << 19);
      endcase
      if ($urandom_range(0, 3) == 0) inten = INT_W'($urandom_range(0, 4095)) - 32'd2048;
      else                           inten = INT_W'($urandom);
      send_point(wn, inten, 1'b0, none);
   endtask

   // Result checker: compares every strobed result with the oldest expectation.
   always @(posedge clock) begin
      scaled_point_type want;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected result wn=%h int=%h", $time, rsp_wavenumber_out,
                     rsp_intensity_out);
            failed <= 1'b1;
         end else begin
            want = pending_points.pop_front();
            if (rsp_wavenumber_out !== want.wn) begin
               $display("%0t: wavenumber expected %h actual %h", $time, want.wn,
                        rsp_wavenumber_out);
               failed <= 1'b1;
            end
            if (rsp_intensity_out !== want.inten) begin
               $display("%0t: intensity expected %h actual %h", $time, want.inten,
                        rsp_intensity_out);
               failed <= 1'b1;
            end
            if (rsp_overflow !== want.ovf) begin
               $display("%0t: overflow expected %b actual %b", $time, want.ovf,
                        rsp_overflow);
               failed <= 1'b1;
            end
         end
      end
   end

   initial begin
      point_row_type    rows[$];
      scaled_point_type typed_res;
      logic [TEMP_W-1:0] temps[6];
      logic [63:0]      v;

      // Table of 2^-(2^(b-16)) in Q31 by repeated square roots.
      v = 64'd1 << 30;
      for (int b = 15; b >= 0; b--) begin
         v = root_nearest(v << 31);
         exp2_roots[b] = v[31:0];
      end

      // Directed points: zero shift, zero intensity, field extremes, clamp and saturation.
      rows = '{
         '{24'h000000, 32'h7FFFFFFF, 1, 32'h0, 1'b0},
         '{24'h000000, 32'h80000000, 1, 32'h0, 1'b0},
         '{24'h7FFFFF, 32'h00000000, 1, 32'h0, 1'b0},
         '{24'h800000, 32'h00000000, 1, 32'h0, 1'b0},
         '{24'h7FFFFF, 32'h7FFFFFFF, 0, 32'h0, 1'b0},
         '{24'h7FFFFF, 32'h80000000, 0, 32'h0, 1'b0},
         '{24'h800000, 32'h7FFFFFFF, 1, 32'h80000000, 1'b1},
         '{24'h800000, 32'h80000000, 1, 32'h7FFFFFFF, 1'b1},
         '{24'h800000, 32'h00000001, 0, 32'h0, 1'b0},
         '{24'h000001, 32'h7FFFFFFF, 0, 32'h0, 1'b0},
         '{24'hFFFFFF, 32'h7FFFFFFF, 0, 32'h0, 1'b0},
         '{24'h00C800, 32'h00010000, 0, 32'h0, 1'b0},
         '{24'hFF3800, 32'h00010000, 0, 32'h0, 1'b0},
         '{24'h0FA000, 32'hFFFF0000, 0, 32'h0, 1'b0},
         '{24'hF06000, 32'h00FFFFFF, 0, 32'h0, 1'b0},
         '{24'h000100, 32'h80000001, 0, 32'h0, 1'b0},
         '{24'hFFF000, 32'h40000000, 0, 32'h0, 1'b0},
         '{24'h555555, 32'hAAAAAAAA, 0, 32'h0, 1'b0},
         '{24'hAAAAAA, 32'h55555555, 0, 32'h0, 1'b0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) begin
         typed_res = '{rows[r].wn, rows[r].exp_inten, rows[r].exp_ovf};
         send_point(rows[r].wn, rows[r].inten, rows[r].typed, typed_res);
      end

      // Temperature zero acts as an infinitely cold sample: x sits at the clamp.
      write_temperature('0);
      foreach (rows[r]) send_point(rows[r].wn, rows[r].inten, 1'b0, typed_res);

      // Random phases across several temperatures, the extremes among them.
      temps = '{20'd1, 20'hFFFFF, 20'(TEMP_RESET), 20'($urandom_range(1, 20000)),
                20'($urandom_range(1, 1048575)), 20'($urandom_range(16, 160))};
      foreach (temps[p]) begin
         write_temperature(temps[p]);
         for (int n = 0; n < 170; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            // Hold off once in mid-phase until every expected result has come.
            if (n == 85 && p == 2) begin
               start <= 1'b0;
               @(posedge clock);
               wait (pending_points.size() == 0);
            end
            send_random_point();
         end
      end

      start <= 1'b0;
      wait (pending_points.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
